// File: hdl/sparse_range_binding_table_core_macros.svh
// ----------------------------------------------------------------------------
// Sparse range binding table assertion macros
// Shared property shorthands, sampled on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_RANGE_BINDING_TABLE_CORE_MACROS_SVH
`define SPARSE_RANGE_BINDING_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SRBT_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srbt check failed");

// next-cycle implication
`define SRBT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srbt check failed");

`endif

// File: hdl/srbt_pkg.sv
// ----------------------------------------------------------------------------
// Sparse range binding table package
// Table geometry, field widths, status codes and shared structs.
// ----------------------------------------------------------------------------
package srbt_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ADDR_W      = IDX_W + 1;
  localparam int unsigned RAM_DEPTH   = 2 ** ADDR_W;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W       = (CNT_W > 4) ? CNT_W : 4;

  // field widths
  localparam int unsigned OFS_W  = 40;
  localparam int unsigned RES_W  = 32;
  localparam int unsigned MID_W  = 32;
  localparam int unsigned EIX_W  = 4;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned ECNT_W = 5;
  localparam int unsigned SUM_W  = OFS_W + 1;
  localparam int unsigned ALU_W  = SUM_W + 1;

  localparam logic [MID_W-1:0] UNBOUND_MEMORY = '0;

  typedef enum logic [ST_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NOT_TRACKED = 2'd1,
    STATUS_FULL        = 2'd2,
    STATUS_BAD_INDEX   = 2'd3
  } status_e;

  typedef enum logic {
    OP_BIND = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    logic [OFS_W-1:0] rng_start;
    logic [MID_W-1:0] mem_id;
    logic [OFS_W-1:0] mem_start;
    logic [OFS_W-1:0] rng_len;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic             neg;
    logic             zero;
  } alu_res_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

endpackage

// File: hdl/srbt_alu.sv
// ----------------------------------------------------------------------------
// Sparse range binding table shared adder
// One 41-bit add/subtract with sign and zero flags, reused for every end,
// difference and offset the unbind walk needs.
// ----------------------------------------------------------------------------
module srbt_alu (
  input  logic [srbt_pkg::SUM_W-1:0] a_i,
  input  logic [srbt_pkg::SUM_W-1:0] b_i,
  input  logic                       sub_i,
  output srbt_pkg::alu_res_t         res_o
);
  import srbt_pkg::*;

  logic [ALU_W-1:0] full;

  // one extra bit so the borrow shows up as the sign
  always_comb begin
    if (sub_i) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
    res_o.value = full[SUM_W-1:0];
    res_o.neg   = full[ALU_W-1];
    res_o.zero  = (full == '0);
  end

endmodule

// File: hdl/srbt_table.sv
// ----------------------------------------------------------------------------
// Sparse range binding table storage
// Two banks of entries in one memory, one write port and one registered
// read port; the unbind walk reads one bank and compacts into the other.
// ----------------------------------------------------------------------------
module srbt_table (
  input  logic              clk_i,
  input  srbt_pkg::tbl_wr_t wr_i,
  input  srbt_pkg::tbl_rd_t rd_i,
  output srbt_pkg::entry_t  rdata_o
);
  import srbt_pkg::*;

  entry_t mem_q [RAM_DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sparse_range_binding_table_core.sv
// ----------------------------------------------------------------------------
// Sparse range binding table core
// Ordered table of range-to-memory bindings for one tracked resource, with
// append, range unbind (remove, trim, split) and single-entry read.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  cfg      cfg_valid_i / cfg_ready_o  cfg_data_i (tracked resource id)
//  in       in_valid_i / in_ready_o    operation .. entry_index
//  out      out_valid_o / out_ready_i  status .. entry_length
//
//  unbind walks the table on the single shared 41-bit adder, six operations
//  per entry, and stops early when the table overflows
//  in_ready_o is high only while idle; cfg is always ready
//  a finished result waits in the output register, the next transaction is
//  taken meanwhile and holds in its last cycle until that result drains;
//  the table needs no clearing after reset
// ----------------------------------------------------------------------------
module sparse_range_binding_table_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srbt_pkg::RES_W-1:0]  cfg_data_i,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [srbt_pkg::RES_W-1:0]  resource_id_i,
  input  logic [srbt_pkg::OFS_W-1:0]  range_start_i,
  input  logic [srbt_pkg::MID_W-1:0]  memory_id_i,
  input  logic [srbt_pkg::OFS_W-1:0]  memory_start_i,
  input  logic [srbt_pkg::OFS_W-1:0]  range_length_i,
  input  logic [srbt_pkg::EIX_W-1:0]  entry_index_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [srbt_pkg::ST_W-1:0]   status_o,
  output logic [srbt_pkg::ECNT_W-1:0] entry_count_o,
  output logic [srbt_pkg::OFS_W-1:0]  entry_range_start_o,
  output logic [srbt_pkg::MID_W-1:0]  entry_memory_id_o,
  output logic [srbt_pkg::OFS_W-1:0]  entry_memory_start_o,
  output logic [srbt_pkg::OFS_W-1:0]  entry_length_o
);
  import srbt_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_APPEND = 4'd1;
  localparam logic [3:0] S_UE     = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_BE     = 4'd4;
  localparam logic [3:0] S_D1     = 4'd5;
  localparam logic [3:0] S_D3     = 4'd6;
  localparam logic [3:0] S_D2     = 4'd7;
  localparam logic [3:0] S_D4     = 4'd8;
  localparam logic [3:0] S_MS     = 4'd9;
  localparam logic [3:0] S_EVAL   = 4'd10;
  localparam logic [3:0] S_SPLIT  = 4'd11;
  localparam logic [3:0] S_COMMIT = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // control state
  logic [3:0]       state_q, state_d;
  logic [RES_W-1:0] tracked_q;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             ok_q, ok_d;
  logic             rd_ok_q, rd_ok_d;
  status_e          pend_q, pend_d;
  logic             out_valid_q, out_valid_d;

  // datapath registers
  logic [OFS_W-1:0] us_q, len_q, msi_q;
  logic [MID_W-1:0] mid_q;
  logic [SUM_W-1:0] ue_q, be_q;
  alu_res_t         d1_q, d2_q, d3_q;
  logic             d4_neg_q;
  logic [OFS_W-1:0] msum_q;
  status_e          status_q;
  logic [ECNT_W-1:0] ecnt_q;
  entry_t           ent_q;

  // shared adder and table ports
  logic [SUM_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  alu_res_t         alu_res;
  tbl_wr_t          wr;
  tbl_rd_t          rd;
  entry_t           e;

  logic             in_acc;
  logic             load_out;
  logic [CMP_W-1:0] idx_ext, cnt_ext;
  logic             cov_lo, cov_hi, over_lo, under_hi;
  logic             n_full1, n_full2, cnt_full;
  entry_t           head_piece, tail_piece, keep_piece;

  srbt_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  srbt_table u_table (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (e)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;

  assign idx_ext  = CMP_W'(entry_index_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign cnt_full = (count_q >= CNT_W'(TABLE_DEPTH));
  assign n_full1  = (n_q >= CNT_W'(TABLE_DEPTH));
  assign n_full2  = ((CNT_W+1)'(n_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(TABLE_DEPTH));

  // overlap classification of the current entry against the unbind range
  assign cov_lo   = d1_q.neg | d1_q.zero;     // unbind start at or before entry start
  assign cov_hi   = d2_q.neg | d2_q.zero;     // unbind end at or after entry end
  assign over_lo  = ~d3_q.neg & ~d3_q.zero;   // unbind end past entry start
  assign under_hi = d4_neg_q;                 // unbind start before entry end

  // candidate pieces of the current entry
  always_comb begin
    head_piece         = e;
    head_piece.rng_len = d1_q.value[OFS_W-1:0];

    tail_piece           = e;
    tail_piece.rng_start = ue_q[OFS_W-1:0];
    tail_piece.mem_start = msum_q;
    tail_piece.rng_len   = d2_q.value[OFS_W-1:0];

    if (cov_lo && over_lo) begin
      keep_piece = tail_piece;
    end else if (under_hi && cov_hi) begin
      keep_piece = head_piece;
    end else begin
      keep_piece = e;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    count_d     = count_q;
    i_d         = i_q;
    n_d         = n_q;
    ok_d        = ok_q;
    rd_ok_d     = rd_ok_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    wr          = '0;
    rd          = '0;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    // output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rd_ok_d = 1'b0;
          pend_d  = STATUS_OK;
          if (op_e'(operation_i) == OP_READ) begin
            if (idx_ext < cnt_ext) begin
              rd.en   = 1'b1;
              rd.addr = {bank_q, idx_ext[IDX_W-1:0]};
              rd_ok_d = 1'b1;
            end else begin
              pend_d = STATUS_BAD_INDEX;
            end
            state_d = S_DONE;
          end else if (resource_id_i != tracked_q) begin
            pend_d  = STATUS_NOT_TRACKED;
            state_d = S_DONE;
          end else if (memory_id_i != UNBOUND_MEMORY) begin
            if (cnt_full) begin
              pend_d  = STATUS_FULL;
              state_d = S_DONE;
            end else begin
              state_d = S_APPEND;
            end
          end else begin
            i_d     = '0;
            n_d     = '0;
            ok_d    = 1'b1;
            state_d = S_UE;
          end
        end
      end

      S_APPEND: begin
        wr.en   = 1'b1;
        wr.addr = {bank_q, count_q[IDX_W-1:0]};
        wr.data = '{rng_start: us_q, mem_id: mid_q, mem_start: msi_q, rng_len: len_q};
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end

      // unbind end
      S_UE: begin
        alu_a   = {1'b0, us_q};
        alu_b   = {1'b0, len_q};
        state_d = S_FETCH;
      end

      S_FETCH: begin
        if (i_q == count_q) begin
          state_d = S_COMMIT;
        end else begin
          rd.en   = 1'b1;
          rd.addr = {bank_q, i_q[IDX_W-1:0]};
          state_d = S_BE;
        end
      end

      // entry end
      S_BE: begin
        alu_a   = {1'b0, e.rng_start};
        alu_b   = {1'b0, e.rng_len};
        state_d = S_D1;
      end

      // unbind start minus entry start
      S_D1: begin
        alu_a   = {1'b0, us_q};
        alu_b   = {1'b0, e.rng_start};
        alu_sub = 1'b1;
        state_d = S_D3;
      end

      // unbind end minus entry start
      S_D3: begin
        alu_a   = ue_q;
        alu_b   = {1'b0, e.rng_start};
        alu_sub = 1'b1;
        state_d = S_D2;
      end

      // entry end minus unbind end
      S_D2: begin
        alu_a   = be_q;
        alu_b   = ue_q;
        alu_sub = 1'b1;
        state_d = S_D4;
      end

      // unbind start minus entry end
      S_D4: begin
        alu_a   = {1'b0, us_q};
        alu_b   = be_q;
        alu_sub = 1'b1;
        state_d = S_MS;
      end

      // advanced memory offset
      S_MS: begin
        alu_a   = {1'b0, e.mem_start};
        alu_b   = d3_q.value;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        if (cov_lo && cov_hi) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_FETCH;
        end else if (!cov_lo && !cov_hi) begin
          if (n_full2) begin
            ok_d    = 1'b0;
            state_d = S_COMMIT;
          end else begin
            wr.en   = 1'b1;
            wr.addr = {~bank_q, n_q[IDX_W-1:0]};
            wr.data = head_piece;
            n_d     = n_q + CNT_W'(1);
            state_d = S_SPLIT;
          end
        end else begin
          if (n_full1) begin
            ok_d    = 1'b0;
            state_d = S_COMMIT;
          end else begin
            wr.en   = 1'b1;
            wr.addr = {~bank_q, n_q[IDX_W-1:0]};
            wr.data = keep_piece;
            n_d     = n_q + CNT_W'(1);
            i_d     = i_q + CNT_W'(1);
            state_d = S_FETCH;
          end
        end
      end

      S_SPLIT: begin
        wr.en   = 1'b1;
        wr.addr = {~bank_q, n_q[IDX_W-1:0]};
        wr.data = tail_piece;
        n_d     = n_q + CNT_W'(1);
        i_d     = i_q + CNT_W'(1);
        state_d = S_FETCH;
      end

      // swap banks only when the whole walk fit
      S_COMMIT: begin
        if (ok_q) begin
          bank_d  = ~bank_q;
          count_d = n_q;
          pend_d  = STATUS_OK;
        end else begin
          pend_d = STATUS_FULL;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tracked_q   <= '0;
      bank_q      <= 1'b0;
      count_q     <= '0;
      i_q         <= '0;
      n_q         <= '0;
      ok_q        <= 1'b0;
      rd_ok_q     <= 1'b0;
      pend_q      <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      count_q     <= count_d;
      i_q         <= i_d;
      n_q         <= n_d;
      ok_q        <= ok_d;
      rd_ok_q     <= rd_ok_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tracked_q <= cfg_data_i;
      end
    end
  end

  // input capture and adder results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      us_q  <= range_start_i;
      len_q <= range_length_i;
      mid_q <= memory_id_i;
      msi_q <= memory_start_i;
    end
    case (state_q)
      S_UE:    ue_q     <= alu_res.value;
      S_BE:    be_q     <= alu_res.value;
      S_D1:    d1_q     <= alu_res;
      S_D3:    d3_q     <= alu_res;
      S_D2:    d2_q     <= alu_res;
      S_D4:    d4_neg_q <= alu_res.neg;
      S_MS:    msum_q   <= alu_res.value[OFS_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= pend_q;
      ecnt_q   <= ECNT_W'(count_q);
      if (rd_ok_q) begin
        ent_q <= e;
      end else begin
        ent_q <= '0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign entry_count_o        = ecnt_q;
  assign entry_range_start_o  = ent_q.rng_start;
  assign entry_memory_id_o    = ent_q.mem_id;
  assign entry_memory_start_o = ent_q.mem_start;
  assign entry_length_o       = ent_q.rng_len;

endmodule

// File: hdl/srbt_checker.sv
// ----------------------------------------------------------------------------
// Sparse range binding table port checker
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "sparse_range_binding_table_core_macros.svh"

module srbt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [srbt_pkg::ST_W-1:0]   status_o,
  input logic [srbt_pkg::ECNT_W-1:0] entry_count_o,
  input logic [srbt_pkg::OFS_W-1:0]  entry_range_start_o,
  input logic [srbt_pkg::MID_W-1:0]  entry_memory_id_o,
  input logic [srbt_pkg::OFS_W-1:0]  entry_memory_start_o,
  input logic [srbt_pkg::OFS_W-1:0]  entry_length_o
);
  import srbt_pkg::*;

  logic entry_empty;

  // all entry fields of the result are zero
  assign entry_empty = (entry_memory_id_o == '0) && (entry_length_o == '0) &&
                       (entry_range_start_o == '0) && (entry_memory_start_o == '0);

  // an accepted transaction makes the block busy in the cycle after
  `SRBT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // reported count never exceeds the table
  `SRBT_ASSERT_IMPLY(a_count_bound, out_valid_o, int'(entry_count_o) <= TABLE_DEPTH)

  // failed transactions carry an empty entry
  `SRBT_ASSERT_IMPLY(a_fail_clears_entry, out_valid_o && (status_o != STATUS_OK), entry_empty)

  // stalled result holds
  `SRBT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(entry_count_o))

endmodule

bind sparse_range_binding_table_core srbt_checker u_srbt_checker (.*);
